// ----- rtl/qas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qas_pkg: shared types and constants of the quoted argument splitter
// Character codes, count limit, queue sizing and the front-to-back request.
// ----------------------------------------------------------------------------
package qas_pkg;

  localparam int MAX_ARGS    = 1023;
  localparam int COUNT_W     = 10;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int LIMIT_INT   = (MAX_ARGS < COUNT_MAX) ? MAX_ARGS : COUNT_MAX;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One request: one or two output bytes caused by one input byte.
  typedef struct packed {
    logic               dual;
    logic [7:0]         lead_byte;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] count;
    logic               done;
  } qas_req_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qas_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qas_front: byte classifier
// Accepts command bytes, tracks word/quote/escape state and the argument
// count, and issues one request per byte that produces output.
// ----------------------------------------------------------------------------
module qas_front import qas_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output qas_req_t        q_req
);

  logic               in_word_r, in_word_nxt;
  logic               esc_r, esc_nxt;
  logic               quote_open_r, quote_open_nxt;
  logic               quote_dq_r, quote_dq_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               accept;
  logic               emit;
  logic [7:0]         open_char;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept && emit;
  assign open_char = quote_dq_r ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    in_word_nxt     = in_word_r;
    esc_nxt         = esc_r;
    quote_open_nxt  = quote_open_r;
    quote_dq_nxt    = quote_dq_r;
    count_nxt       = count_r;
    emit            = 1'b0;
    q_req.dual      = 1'b0;
    q_req.lead_byte = CH_BSLASH;
    q_req.data_byte = in_byte;
    q_req.done      = 1'b0;
    if (in_byte == CH_NUL) begin
      emit           = 1'b1;
      q_req.done     = 1'b1;
      in_word_nxt    = 1'b0;
      esc_nxt        = 1'b0;
      quote_open_nxt = 1'b0;
      quote_dq_nxt   = 1'b0;
      count_nxt      = '0;
    end else if (!in_word_r) begin
      if (!is_ws(in_byte)) begin
        if (count_r < COUNT_LIMIT) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        in_word_nxt    = 1'b1;
        esc_nxt        = (in_byte == CH_BSLASH);
        quote_open_nxt = is_quote(in_byte);
        quote_dq_nxt   = (in_byte == CH_DQUOTE);
        emit           = (in_byte != CH_BSLASH) && !is_quote(in_byte);
      end
    end else if (esc_r) begin
      q_req.dual = quote_open_r && !((in_byte == open_char) || (in_byte == CH_BSLASH));
      emit       = 1'b1;
      esc_nxt    = 1'b0;
    end else if (in_byte == CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else if (quote_open_r && (in_byte == open_char)) begin
      quote_open_nxt = 1'b0;
    end else if (!quote_open_r && is_quote(in_byte)) begin
      quote_open_nxt = 1'b1;
      quote_dq_nxt   = (in_byte == CH_DQUOTE);
    end else if (!quote_open_r && is_ws(in_byte)) begin
      in_word_nxt     = 1'b0;
      emit            = 1'b1;
      q_req.data_byte = CH_NUL;
    end else begin
      emit = 1'b1;
    end
    q_req.count = (in_byte == CH_NUL) ? count_r : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r    <= 1'b0;
      esc_r        <= 1'b0;
      quote_open_r <= 1'b0;
      quote_dq_r   <= 1'b0;
      count_r      <= '0;
    end else if (accept) begin
      in_word_r    <= in_word_nxt;
      esc_r        <= esc_nxt;
      quote_open_r <= quote_open_nxt;
      quote_dq_r   <= quote_dq_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qas_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qas_queue: request queue
// Small FIFO of requests between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module qas_queue import qas_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  qas_req_t      push_req,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output qas_req_t      head_req
);

  qas_req_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("request popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue occupancy out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue occupancy did not follow push");

endmodule

`default_nettype wire

// ----- rtl/qas_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qas_back: output sequencer
// Drains requests into a registered output, one or two bytes per request.
// ----------------------------------------------------------------------------
module qas_back import qas_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  qas_req_t         head_req,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [COUNT_W-1:0] out_arg_total,
  output logic             out_string_done,
  output logic             out_run_last
);

  logic               valid_r, valid_nxt;
  logic               half_r, half_nxt;
  logic [7:0]         byte_r;
  logic [COUNT_W-1:0] total_r;
  logic               done_r;
  logic               last_r;
  logic               load;
  logic               first_half;

  assign load       = !valid_r || !out_stall;
  assign first_half = head_req.dual && !half_r;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        half_nxt = first_half;
        pop      = !first_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      byte_r  <= first_half ? head_req.lead_byte : head_req.data_byte;
      total_r <= head_req.count;
      done_r  <= head_req.done;
      last_r  <= !first_half;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_arg_total   = total_r;
  assign out_string_done = done_r;
  assign out_run_last    = last_r;

  a_half_only_dual: assert property (@(posedge clk) disable iff (!rst_n)
    (half_r && head_valid) |-> head_req.dual)
    else $error("second half pending on a single-byte request");

  a_pop_after_half: assert property (@(posedge clk) disable iff (!rst_n)
    (load && head_valid && half_r) |-> pop)
    else $error("second half sent without releasing the request");

  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && head_valid && first_half) |=> (valid_r && !last_r && half_r))
    else $error("lead byte of a pair marked last");

endmodule

`default_nettype wire

// ----- rtl/quoted_argument_splitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_argument_splitter: shell-style argument splitter
// Splits a byte stream into zero-separated arguments, handling quotes and
// backslash escapes, and reports the argument count on the terminator.
// ----------------------------------------------------------------------------
// Path: a byte accepted by the classifier is written into the request queue, and
//   its first result is loaded from the queue head into the output register.
// Throughput: one byte per cycle while the request queue is not full; a byte
//   that yields an escaped pair sends both bytes in turn through the single output
//   register; a 4-entry request queue lets input and output stall independently.
// Reset: synchronous, active low; clears parser state, count, queue and
//   output valid.
// ----------------------------------------------------------------------------
module quoted_argument_splitter import qas_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic [COUNT_W-1:0]      out_arg_total,
  output logic                    out_string_done,
  output logic                    out_run_last
);

  qas_req_t push_req;
  qas_req_t head_req;
  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;

  qas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (full),
    .q_push   (push),
    .q_req    (push_req)
  );

  qas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  qas_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_req        (head_req),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_arg_total   (out_arg_total),
    .out_string_done (out_string_done),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire
